// ===== rtl/core/dhfk_pkg.sv =====
package dhfk_pkg;

    localparam int FRACTION_BITS_DEF = 24;
    localparam int TRIG_STEPS_DEF    = 24;
    localparam int CORDIC_MAX        = 30;
    localparam int POSE_ENTRIES      = 12;

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_JOINT = 1'b1;

    localparam logic [2:0] LK_ST_CA = 3'd0;
    localparam logic [2:0] LK_ST_SA = 3'd1;
    localparam logic [2:0] LK_A_CT  = 3'd2;
    localparam logic [2:0] LK_CT_CA = 3'd3;
    localparam logic [2:0] LK_CT_SA = 3'd4;
    localparam logic [2:0] LK_A_ST  = 3'd5;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       trig_step;
        logic [4:0] step;
        logic       link_issue;
        logic [2:0] link_sel;
        logic       pose_issue;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] kidx;
        logic       commit;
    } dhfk_cmd_t;

    typedef struct packed {
        logic last_joint;
    } dhfk_stat_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // bit 32 flags saturation
    function automatic logic [32:0] sat32(input logic signed [71:0] v);
        logic [32:0] r;
        if (v > 72'sd2147483647)
        begin
            r = {1'b1, 32'h7FFFFFFF};
        end
        else if (v < -72'sd2147483648)
        begin
            r = {1'b1, 32'h80000000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/dh_forward_kinematics_unit.sv =====
// channel  | handshake             | payload
// in       | in_valid / in_ready   | op, row_index, row_value_0..3, link and joint fields
// out      | out_valid / out_ready | out_row, out_value_0..3, saturated, last_row
//
// load beat: taken in idle with no busy state. joint beat: busy time is set by the
// two cordic lanes (one step per cycle) and one shared multiplier for 6 link and 36 pose
// products. a last joint then holds three output beats, one per row.
// rst_n clears control and restores the identity pose and the saturation flag.
// in_ready low from a joint beat until commit and any rows taken; out_ready may stall.
module dh_forward_kinematics_unit
    import dhfk_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int TRIG_STEPS    = TRIG_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [1:0]         row_index,
    input  logic signed [31:0] row_value_0,
    input  logic signed [31:0] row_value_1,
    input  logic signed [31:0] row_value_2,
    input  logic signed [31:0] row_value_3,
    input  logic signed [31:0] link_length,
    input  logic [31:0]        link_twist,
    input  logic signed [31:0] link_offset,
    input  logic [31:0]        theta_zero,
    input  logic [31:0]        joint_pos,
    input  logic               last_joint,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_row,
    output logic signed [31:0] out_value_0,
    output logic signed [31:0] out_value_1,
    output logic signed [31:0] out_value_2,
    output logic signed [31:0] out_value_3,
    output logic               saturated,
    output logic               last_row
);

    dhfk_cmd_t  cmd;
    dhfk_stat_t stat;

    dhfk_ctrl #(
        .TRIG_STEPS (TRIG_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_row   (out_row),
        .last_row  (last_row),
        .stat      (stat),
        .cmd       (cmd)
    );

    dhfk_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .row_index    (row_index),
        .row_value_0  (row_value_0),
        .row_value_1  (row_value_1),
        .row_value_2  (row_value_2),
        .row_value_3  (row_value_3),
        .link_length  (link_length),
        .link_twist   (link_twist),
        .link_offset  (link_offset),
        .theta_zero   (theta_zero),
        .joint_pos    (joint_pos),
        .last_joint   (last_joint),
        .out_value_0  (out_value_0),
        .out_value_1  (out_value_1),
        .out_value_2  (out_value_2),
        .out_value_3  (out_value_3),
        .saturated    (saturated)
    );

endmodule

// ===== rtl/core/dhfk_ctrl.sv =====
module dhfk_ctrl
    import dhfk_pkg::*;
#(
    parameter int TRIG_STEPS = TRIG_STEPS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_row,
    output logic       last_row,
    input  dhfk_stat_t stat,
    output dhfk_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TRIG   = 3'd1;
    localparam logic [2:0] S_LINK   = 3'd2;
    localparam logic [2:0] S_LDRAIN = 3'd3;
    localparam logic [2:0] S_POSE   = 3'd4;
    localparam logic [2:0] S_PDRAIN = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    localparam logic [4:0] LAST_STEP = 5'(TRIG_STEPS - 1);

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] sel_reg, sel_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic [1:0] k_reg, k_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == S_EMIT);
    assign out_row   = row_reg;
    assign last_row  = (row_reg == 2'd2);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && op == OP_JOINT)
                begin
                    state_next = S_TRIG;
                    cnt_next   = '0;
                end
            end
            S_TRIG:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_LINK;
                    sel_next   = LK_ST_CA;
                end
            end
            S_LINK:
            begin
                sel_next = sel_reg + 3'd1;
                if (sel_reg == LK_A_ST)
                begin
                    state_next = S_LDRAIN;
                end
            end
            S_LDRAIN:
            begin
                state_next = S_POSE;
                row_next   = '0;
                col_next   = '0;
                k_next     = '0;
            end
            S_POSE:
            begin
                if (k_reg == 2'd2)
                begin
                    k_next = '0;
                    if (col_reg == 2'd3)
                    begin
                        col_next = '0;
                        if (row_reg == 2'd2)
                        begin
                            state_next = S_PDRAIN;
                            row_next   = '0;
                        end
                        else
                        begin
                            row_next = row_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 2'd1;
                    end
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_PDRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                row_next   = '0;
                state_next = stat.last_joint ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    if (row_reg == 2'd2)
                    begin
                        state_next = S_IDLE;
                        row_next   = '0;
                    end
                    else
                    begin
                        row_next = row_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.load       = accept && (op == OP_LOAD);
        cmd.start      = accept && (op == OP_JOINT);
        cmd.trig_step  = (state_reg == S_TRIG);
        cmd.step       = cnt_reg;
        cmd.link_issue = (state_reg == S_LINK);
        cmd.link_sel   = sel_reg;
        cmd.pose_issue = (state_reg == S_POSE);
        cmd.row        = row_reg;
        cmd.col        = col_reg;
        cmd.kidx       = k_reg;
        cmd.commit     = (state_reg == S_COMMIT);
    end

endmodule

// ===== rtl/core/dhfk_datapath.sv =====
module dhfk_datapath
    import dhfk_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dhfk_cmd_t          cmd,
    output dhfk_stat_t         stat,
    input  logic [1:0]         row_index,
    input  logic signed [31:0] row_value_0,
    input  logic signed [31:0] row_value_1,
    input  logic signed [31:0] row_value_2,
    input  logic signed [31:0] row_value_3,
    input  logic signed [31:0] link_length,
    input  logic [31:0]        link_twist,
    input  logic signed [31:0] link_offset,
    input  logic [31:0]        theta_zero,
    input  logic [31:0]        joint_pos,
    input  logic               last_joint,
    output logic signed [31:0] out_value_0,
    output logic signed [31:0] out_value_1,
    output logic signed [31:0] out_value_2,
    output logic signed [31:0] out_value_3,
    output logic               saturated
);

    localparam int SH  = 30 - FRACTION_BITS;
    localparam int SHM = (SH > 0) ? SH - 1 : 0;
    localparam logic signed [33:0] TRIG_HALF = 34'sd1 <<< SHM;
    localparam logic signed [69:0] MUL_HALF  = 70'sd1 <<< (FRACTION_BITS - 1);
    localparam logic signed [31:0] ONE       = 32'sd1 <<< FRACTION_BITS;

    logic signed [31:0] pose_reg [POSE_ENTRIES];
    logic signed [31:0] new_reg  [POSE_ENTRIES];
    logic signed [31:0] lk_reg   [POSE_ENTRIES];
    logic signed [31:0] a_reg, d_reg;
    logic signed [33:0] cx_reg [2];
    logic signed [33:0] cy_reg [2];
    logic signed [32:0] cz_reg [2];
    logic [1:0]         q_reg  [2];
    logic               last_reg;
    logic               sat_reg;
    logic signed [69:0] prod_reg;
    logic signed [71:0] acc_reg;
    logic               tl_reg, tp_reg;
    logic [2:0]         tsel_reg;
    logic [1:0]         trow_reg, tcol_reg, tk_reg;

    logic [31:0]        theta;
    logic [31:0]        ang [2];
    logic [1:0]         q0 [2];
    logic [31:0]        z0 [2];
    logic signed [33:0] nx [2];
    logic signed [33:0] ny [2];
    logic signed [32:0] nz [2];
    logic signed [34:0] cv [2];
    logic signed [34:0] sv [2];
    logic signed [33:0] rx, ry;
    logic signed [34:0] ma, mb;
    logic signed [69:0] rnd;
    logic signed [71:0] rnd_x, acc_base, acc_sum;
    logic [32:0]        lk_sat, pose_sat;
    logic [32:0]        sct, sst, sca, ssa;
    logic [3:0]         pidx, lidx, tidx;

    assign stat.last_joint = last_reg;
    assign saturated       = sat_reg;
    assign out_value_0     = pose_reg[{cmd.row, 2'd0}];
    assign out_value_1     = pose_reg[{cmd.row, 2'd1}];
    assign out_value_2     = pose_reg[{cmd.row, 2'd2}];
    assign out_value_3     = pose_reg[{cmd.row, 2'd3}];

    assign theta  = theta_zero + joint_pos;
    assign ang[0] = theta;
    assign ang[1] = link_twist;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            q0[l] = 2'((ang[l] + 32'h20000000) >> 30);
            z0[l] = ang[l] - {q0[l], 30'd0};
            if (cz_reg[l] >= 0)
            begin
                nx[l] = cx_reg[l] - (cy_reg[l] >>> cmd.step);
                ny[l] = cy_reg[l] + (cx_reg[l] >>> cmd.step);
                nz[l] = cz_reg[l] - $signed({1'b0, atan_turn(cmd.step)});
            end
            else
            begin
                nx[l] = cx_reg[l] + (cy_reg[l] >>> cmd.step);
                ny[l] = cy_reg[l] - (cx_reg[l] >>> cmd.step);
                nz[l] = cz_reg[l] + $signed({1'b0, atan_turn(cmd.step)});
            end
            if (SH == 0)
            begin
                rx = cx_reg[l];
                ry = cy_reg[l];
            end
            else
            begin
                rx = (cx_reg[l] + TRIG_HALF) >>> SH;
                ry = (cy_reg[l] + TRIG_HALF) >>> SH;
            end
            case (q_reg[l])
                2'd0:
                begin
                    cv[l] = 35'(rx);
                    sv[l] = 35'(ry);
                end
                2'd1:
                begin
                    cv[l] = -35'(ry);
                    sv[l] = 35'(rx);
                end
                2'd2:
                begin
                    cv[l] = -35'(rx);
                    sv[l] = -35'(ry);
                end
                default:
                begin
                    cv[l] = 35'(ry);
                    sv[l] = -35'(rx);
                end
            endcase
        end
    end

    assign sct = sat32(72'(cv[0]));
    assign sst = sat32(72'(sv[0]));
    assign sca = sat32(72'(cv[1]));
    assign ssa = sat32(72'(sv[1]));

    assign pidx = {cmd.row, 2'b00} + {2'b00, cmd.kidx};
    assign lidx = {cmd.kidx, 2'b00} + {2'b00, cmd.col};
    assign tidx = {trow_reg, tcol_reg};

    always_comb
    begin
        ma = '0;
        mb = '0;
        if (cmd.pose_issue)
        begin
            ma = 35'(pose_reg[pidx]);
            mb = 35'(lk_reg[lidx]);
        end
        else
        begin
            case (cmd.link_sel)
                LK_ST_CA:
                begin
                    ma = sv[0];
                    mb = cv[1];
                end
                LK_ST_SA:
                begin
                    ma = sv[0];
                    mb = sv[1];
                end
                LK_A_CT:
                begin
                    ma = 35'(a_reg);
                    mb = cv[0];
                end
                LK_CT_CA:
                begin
                    ma = cv[0];
                    mb = cv[1];
                end
                LK_CT_SA:
                begin
                    ma = cv[0];
                    mb = sv[1];
                end
                LK_A_ST:
                begin
                    ma = 35'(a_reg);
                    mb = sv[0];
                end
                default:
                begin
                    ma = '0;
                    mb = '0;
                end
            endcase
        end
    end

    assign rnd   = (prod_reg + MUL_HALF) >>> FRACTION_BITS;
    assign rnd_x = 72'(rnd);

    always_comb
    begin
        if (tsel_reg == LK_ST_CA || tsel_reg == LK_CT_SA)
        begin
            lk_sat = sat32(-rnd_x);
        end
        else
        begin
            lk_sat = sat32(rnd_x);
        end
        if (tk_reg == 2'd0)
        begin
            acc_base = (tcol_reg == 2'd3) ? 72'(pose_reg[{trow_reg, 2'd3}]) : '0;
        end
        else
        begin
            acc_base = acc_reg;
        end
        acc_sum  = acc_base + rnd_x;
        pose_sat = sat32(acc_sum);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        tl_reg   <= cmd.link_issue;
        tp_reg   <= cmd.pose_issue;
        tsel_reg <= cmd.link_sel;
        trow_reg <= cmd.row;
        tcol_reg <= cmd.col;
        tk_reg   <= cmd.kidx;
        if (cmd.start)
        begin
            a_reg    <= link_length;
            d_reg    <= link_offset;
            last_reg <= last_joint;
            for (int l = 0; l < 2; l++)
            begin
                cx_reg[l] <= GAIN_Q30;
                cy_reg[l] <= '0;
                cz_reg[l] <= {z0[l][31], z0[l]};
                q_reg[l]  <= q0[l];
            end
        end
        else if (cmd.trig_step)
        begin
            for (int l = 0; l < 2; l++)
            begin
                cx_reg[l] <= nx[l];
                cy_reg[l] <= ny[l];
                cz_reg[l] <= nz[l];
            end
        end
        if (cmd.link_issue)
        begin
            lk_reg[0]  <= sct[31:0];
            lk_reg[4]  <= sst[31:0];
            lk_reg[8]  <= '0;
            lk_reg[9]  <= ssa[31:0];
            lk_reg[10] <= sca[31:0];
            lk_reg[11] <= d_reg;
        end
        if (tl_reg)
        begin
            case (tsel_reg)
                LK_ST_CA: lk_reg[1] <= lk_sat[31:0];
                LK_ST_SA: lk_reg[2] <= lk_sat[31:0];
                LK_A_CT:  lk_reg[3] <= lk_sat[31:0];
                LK_CT_CA: lk_reg[5] <= lk_sat[31:0];
                LK_CT_SA: lk_reg[6] <= lk_sat[31:0];
                default:  lk_reg[7] <= lk_sat[31:0];
            endcase
        end
        if (tp_reg)
        begin
            acc_reg <= acc_sum;
            if (tk_reg == 2'd2)
            begin
                new_reg[tidx] <= pose_sat[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < POSE_ENTRIES; e++)
            begin
                pose_reg[e] <= (e == 0 || e == 5 || e == 10) ? ONE : '0;
            end
            sat_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && row_index != 2'd3)
            begin
                pose_reg[{row_index, 2'd0}] <= row_value_0;
                pose_reg[{row_index, 2'd1}] <= row_value_1;
                pose_reg[{row_index, 2'd2}] <= row_value_2;
                pose_reg[{row_index, 2'd3}] <= row_value_3;
                sat_reg <= 1'b0;
            end
            else if (cmd.commit)
            begin
                for (int e = 0; e < POSE_ENTRIES; e++)
                begin
                    pose_reg[e] <= new_reg[e];
                end
            end
            if ((cmd.link_issue && (sct[32] || sst[32] || sca[32] || ssa[32]))
                || (tl_reg && lk_sat[32])
                || (tp_reg && tk_reg == 2'd2 && pose_sat[32]))
            begin
                sat_reg <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/dhfk_checker.sv =====
module dhfk_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_row,
    input logic [31:0] out_value_0,
    input logic        last_row
);

    // no input beat while rows are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken during row output");

    // last_row marks row two
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_row == (out_row == 2'd2)))
        else $error("last_row mismatch");

    // rows follow back to back in order
    a_row_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_row |=> out_valid && out_row == $past(out_row) + 2'd1)
        else $error("row sequence broken");

    // burst starts at row zero
    a_row_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> out_row == 2'd0)
        else $error("burst did not start at row zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value_0))
        else $error("stalled beat changed");

endmodule

bind dh_forward_kinematics_unit dhfk_checker u_dhfk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_value_0 (out_value_0),
    .last_row    (last_row)
);

// ===== tb/tb_dh_forward_kinematics_unit.sv =====
module tb_dh_forward_kinematics_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import dhfk_pkg::*;

    localparam int FB        = FRACTION_BITS_DEF;
    localparam int STEPS     = TRIG_STEPS_DEF;
    localparam int N_RANDOM  = 420;
    localparam int MAX_CYCLE = 400000;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FB;
    localparam logic signed [31:0] PMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] NMAX = 32'sh80000000;

    typedef struct packed {
        logic              op;
        logic [1:0]        row_index;
        logic signed [31:0] rv0;
        logic signed [31:0] rv1;
        logic signed [31:0] rv2;
        logic signed [31:0] rv3;
        logic signed [31:0] a;
        logic [31:0]        alpha;
        logic signed [31:0] d;
        logic [31:0]        toff;
        logic [31:0]        ang;
        logic               last;
    } beat_t;

    typedef struct packed {
        logic [1:0]         row;
        logic signed [31:0] v0;
        logic signed [31:0] v1;
        logic signed [31:0] v2;
        logic signed [31:0] v3;
        logic               sat;
        logic               last;
    } row_t;

    // directed row with optional typed-in expectation of row 0 of the pose
    typedef struct {
        beat_t b;
        bit    has_row0;
        logic signed [31:0] r0v0;
        logic signed [31:0] r0v3;
        logic  r0sat;
    } vec_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic op;
    logic [1:0] row_index;
    logic signed [31:0] row_value_0;
    logic signed [31:0] row_value_1;
    logic signed [31:0] row_value_2;
    logic signed [31:0] row_value_3;
    logic signed [31:0] link_length;
    logic [31:0] link_twist;
    logic signed [31:0] link_offset;
    logic [31:0] theta_zero;
    logic [31:0] joint_pos;
    logic last_joint;
    logic out_valid;
    logic out_ready;
    logic [1:0] out_row;
    logic signed [31:0] out_value_0;
    logic signed [31:0] out_value_1;
    logic signed [31:0] out_value_2;
    logic signed [31:0] out_value_3;
    logic saturated;
    logic last_row;

    dh_forward_kinematics_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .row_index    (row_index),
        .row_value_0  (row_value_0),
        .row_value_1  (row_value_1),
        .row_value_2  (row_value_2),
        .row_value_3  (row_value_3),
        .link_length  (link_length),
        .link_twist   (link_twist),
        .link_offset  (link_offset),
        .theta_zero   (theta_zero),
        .joint_pos    (joint_pos),
        .last_joint   (last_joint),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_row      (out_row),
        .out_value_0  (out_value_0),
        .out_value_1  (out_value_1),
        .out_value_2  (out_value_2),
        .out_value_3  (out_value_3),
        .saturated    (saturated),
        .last_row     (last_row)
    );

    logic signed [31:0] pose [12];
    logic sat_seen;
    row_t expected_rows[$];
    int errors;
    int cycles;
    bit hold_off;
    bit no_idle;
    bit sink_idle;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLE)
        begin
            $display("dh_forward_kinematics_unit: mismatch");
            $finish;
        end
    end

    function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            sat_seen = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat_seen = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] mul_round(input logic signed [63:0] x,
                                                     input logic signed [63:0] y);
        return floor_shr(x * y + (64'sd1 <<< (FB - 1)), FB);
    endfunction

    function automatic void cordic(input logic [31:0] ang, output logic signed [63:0] c,
                                   output logic signed [63:0] s);
        logic [31:0] q32;
        logic [1:0] quad;
        logic signed [63:0] z;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] nx;
        logic [31:0] res;
        q32 = ang + 32'h20000000;
        quad = q32[31:30];
        res = ang - {quad, 30'd0};
        z = $signed({{32{res[31]}}, res});
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < STEPS && i < CORDIC_MAX; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z = z - $signed({32'd0, atan_turn(i[4:0])});
            end
            else
            begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z = z + $signed({32'd0, atan_turn(i[4:0])});
            end
            x = nx;
        end
        if (FB < 30)
        begin
            x = floor_shr(x + (64'sd1 <<< (29 - FB)), 30 - FB);
            y = floor_shr(y + (64'sd1 <<< (29 - FB)), 30 - FB);
        end
        case (quad)
            2'd0:
            begin
                c = x;
                s = y;
            end
            2'd1:
            begin
                c = -y;
                s = x;
            end
            2'd2:
            begin
                c = -x;
                s = -y;
            end
            default:
            begin
                c = y;
                s = -x;
            end
        endcase
    endfunction

    function automatic void pose_reset();
        for (int k = 0; k < 12; k++)
            pose[k] = 0;
        pose[0] = ONE;
        pose[5] = ONE;
        pose[10] = ONE;
        sat_seen = 1'b0;
    endfunction

    function automatic void chain_link(input beat_t b);
        logic signed [63:0] ct, st, ca, sa, acc;
        logic signed [63:0] lk [12];
        logic signed [31:0] np [12];
        row_t r;
        if (b.op == OP_LOAD)
        begin
            if (b.row_index > 2)
                return;
            pose[b.row_index * 4 + 0] = b.rv0;
            pose[b.row_index * 4 + 1] = b.rv1;
            pose[b.row_index * 4 + 2] = b.rv2;
            pose[b.row_index * 4 + 3] = b.rv3;
            sat_seen = 1'b0;
            return;
        end
        cordic(b.toff + b.ang, ct, st);
        cordic(b.alpha, ca, sa);
        lk[0] = clamp32(ct);
        lk[1] = clamp32(-mul_round(st, ca));
        lk[2] = clamp32(mul_round(st, sa));
        lk[3] = clamp32(mul_round(b.a, ct));
        lk[4] = clamp32(st);
        lk[5] = clamp32(mul_round(ct, ca));
        lk[6] = clamp32(-mul_round(ct, sa));
        lk[7] = clamp32(mul_round(b.a, st));
        lk[8] = 0;
        lk[9] = clamp32(sa);
        lk[10] = clamp32(ca);
        lk[11] = b.d;
        for (int rr = 0; rr < 3; rr++)
            for (int c = 0; c < 4; c++)
            begin
                acc = (c == 3) ? 64'(pose[rr * 4 + 3]) : 64'sd0;
                for (int k = 0; k < 3; k++)
                    acc += mul_round(pose[rr * 4 + k], lk[k * 4 + c]);
                np[rr * 4 + c] = 32'(clamp32(acc));
            end
        for (int k = 0; k < 12; k++)
            pose[k] = np[k];
        if (!b.last)
            return;
        for (int rr = 0; rr < 3; rr++)
        begin
            r.row = rr[1:0];
            r.v0 = pose[rr * 4];
            r.v1 = pose[rr * 4 + 1];
            r.v2 = pose[rr * 4 + 2];
            r.v3 = pose[rr * 4 + 3];
            r.sat = sat_seen;
            r.last = (rr == 2);
            expected_rows.insert(expected_rows.size(), r);
        end
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        errors++;
        $display("row check failed: %s got %h want %h", what, got, exp);
    endtask

    always @(posedge clk)
    begin
        row_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rows.size() == 0)
                report("unexpected row", out_row, 0);
            else
            begin
                e = expected_rows.pop_front();
                if (out_row !== e.row) report("out_row", out_row, e.row);
                if (out_value_0 !== e.v0) report("out_value_0", out_value_0, e.v0);
                if (out_value_1 !== e.v1) report("out_value_1", out_value_1, e.v1);
                if (out_value_2 !== e.v2) report("out_value_2", out_value_2, e.v2);
                if (out_value_3 !== e.v3) report("out_value_3", out_value_3, e.v3);
                if (saturated !== e.sat) report("saturated", saturated, e.sat);
                if (last_row !== e.last) report("last_row", last_row, e.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else if (no_idle || sink_idle)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 30);
    end

    // long receiver hold-off, counted in its own process
    initial
    begin
        hold_off = 1'b0;
        wait (cycles == 3000);
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
    end

    function automatic beat_t blank();
        beat_t b;
        b = '0;
        b.op = OP_JOINT;
        return b;
    endfunction

    function automatic beat_t load_row(input logic [1:0] r, input logic signed [31:0] v0,
                                       input logic signed [31:0] v1,
                                       input logic signed [31:0] v2,
                                       input logic signed [31:0] v3);
        beat_t b;
        b = '0;
        b.op = OP_LOAD;
        b.row_index = r;
        b.rv0 = v0;
        b.rv1 = v1;
        b.rv2 = v2;
        b.rv3 = v3;
        b.last = 1'($urandom_range(1));
        return b;
    endfunction

    function automatic beat_t joint(input logic signed [31:0] a, input logic [31:0] al,
                                    input logic signed [31:0] d, input logic [31:0] t0,
                                    input logic [31:0] q, input logic last);
        beat_t b;
        b = blank();
        b.a = a;
        b.alpha = al;
        b.d = d;
        b.toff = t0;
        b.ang = q;
        b.last = last;
        b.row_index = 2'($urandom_range(3));
        b.rv0 = $urandom;
        b.rv1 = $urandom;
        b.rv2 = $urandom;
        b.rv3 = $urandom;
        return b;
    endfunction

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? PMAX : NMAX;
            default: return $signed($urandom_range(2 * ONE)) - ONE;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_len();
        if ($urandom_range(9) == 0)
            return $urandom;
        return $signed($urandom_range(ONE)) - (ONE >>> 1);
    endfunction

    task automatic send(input beat_t b);
        if (!no_idle)
            while ($urandom_range(99) < 30)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        op <= b.op;
        row_index <= b.row_index;
        row_value_0 <= b.rv0;
        row_value_1 <= b.rv1;
        row_value_2 <= b.rv2;
        row_value_3 <= b.rv3;
        link_length <= b.a;
        link_twist <= b.alpha;
        link_offset <= b.d;
        theta_zero <= b.toff;
        joint_pos <= b.ang;
        last_joint <= b.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chain_link(b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
    endtask

    vec_t table_rows[$];

    function automatic void add(input beat_t b);
        vec_t v;
        v.b = b;
        v.has_row0 = 1'b0;
        table_rows.insert(table_rows.size(), v);
    endfunction

    function automatic void add_known(input beat_t b, input logic signed [31:0] e0,
                                      input logic signed [31:0] e3, input logic es);
        vec_t v;
        v.b = b;
        v.has_row0 = 1'b1;
        v.r0v0 = e0;
        v.r0v3 = e3;
        v.r0sat = es;
        table_rows.insert(table_rows.size(), v);
    endfunction

    initial
    begin
        beat_t b;
        int n;
        bit paused;
        errors = 0;
        cycles = 0;
        paused = 1'b0;
        no_idle = 1'b0;
        sink_idle = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        op = OP_LOAD;
        row_index = '0;
        row_value_0 = '0;
        row_value_1 = '0;
        row_value_2 = '0;
        row_value_3 = '0;
        link_length = '0;
        link_twist = '0;
        link_offset = '0;
        theta_zero = '0;
        joint_pos = '0;
        last_joint = 1'b0;
        pose_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity chain after reset: zero joint leaves identity, d moves z
        add_known(joint(0, 0, 0, 0, 0, 1), ONE, 0, 1'b0);
        add(joint(0, 0, ONE, 0, 0, 1));
        add(joint(ONE, 32'h40000000, 0, 32'h40000000, 0, 1));
        add(joint(ONE, 32'h80000000, 0, 32'hC0000000, 32'h20000000, 1));
        add(joint(NMAX, 32'hFFFFFFFF, PMAX, 32'hFFFFFFFF, 32'hFFFFFFFF, 1));
        add(joint(PMAX, 32'h1FFFFFFF, NMAX, 32'h60000000, 32'hA0000000, 0));
        add(joint(ONE, 32'hE0000000, ONE, 32'h12345678, 32'h9ABCDEF0, 1));
        // ignored load on row three keeps the pose and the flag
        add(load_row(2'd3, PMAX, PMAX, PMAX, PMAX));
        add(joint(0, 0, 0, 0, 0, 1));
        // full reload with extremes clears the flag, then saturates
        add(load_row(2'd0, PMAX, NMAX, PMAX, NMAX));
        add(load_row(2'd1, NMAX, PMAX, 0, PMAX));
        add(load_row(2'd2, 0, 0, PMAX, NMAX));
        add(joint(PMAX, 32'h40000000, PMAX, 0, 0, 1));
        add(joint(0, 0, 0, 0, 0, 1));
        // partial reload: row 0 fresh, flag cleared, other rows kept
        add_known(load_row(2'd0, ONE, 0, 0, 32'sd5), ONE, 32'sd5, 1'b0);
        table_rows[$].b.op = OP_LOAD;
        add_known(joint(0, 0, 0, 0, 0, 1), ONE, 32'sd5, 1'b0);
        add(joint(-ONE, 32'h55555555, -ONE, 32'hAAAAAAAA, 32'h55555555, 1));

        foreach (table_rows[i])
        begin
            send(table_rows[i].b);
            if (table_rows[i].has_row0 && table_rows[i].b.op == OP_JOINT)
            begin
                if (expected_rows[0].v0 !== table_rows[i].r0v0)
                    report("typed row0 col0", expected_rows[0].v0, table_rows[i].r0v0);
                if (expected_rows[0].v3 !== table_rows[i].r0v3)
                    report("typed row0 col3", expected_rows[0].v3, table_rows[i].r0v3);
                if (expected_rows[0].sat !== table_rows[i].r0sat)
                    report("typed row0 sat", expected_rows[0].sat, table_rows[i].r0sat);
            end
        end
        drain();

        n = 0;
        while (n < N_RANDOM)
        begin
            no_idle = (n >= 150 && n < 220);
            if (n >= 300 && !paused)
            begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(9) < 8)
            begin
                // base pose then a short chain ending with the last mark
                for (int r = 0; r < 3; r++)
                begin
                    if ($urandom_range(5) != 0)
                    begin
                        send(load_row(r[1:0], rand_q(), rand_q(), rand_q(), rand_q()));
                        n++;
                    end
                end
                for (int j = $urandom_range(1, 6); j > 0; j--)
                begin
                    send(joint(rand_len(), $urandom, rand_len(), $urandom, $urandom, j == 1));
                    n++;
                end
            end
            else
            begin
                b = ($urandom_range(1)) ?
                    load_row(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom) :
                    joint($urandom, $urandom, $urandom, $urandom, $urandom,
                          1'($urandom_range(1)));
                send(b);
                n++;
            end
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        n = 0;
        while (expected_rows.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_rows.size() == 0)
            $display("dh_forward_kinematics_unit: match");
        else
            $display("dh_forward_kinematics_unit: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dhfk_pkg.sv
rtl/core/dhfk_ctrl.sv
rtl/core/dhfk_datapath.sv
rtl/core/dh_forward_kinematics_unit.sv
rtl/core/dhfk_checker.sv
tb/tb_dh_forward_kinematics_unit.sv
